// File: rtl/mfb_pkg.sv
// shared types, constants and crc helper for the modbus request frame builder
package mfb_pkg;

  localparam int FrameBytes = 8;
  localparam int IdxW       = $clog2(FrameBytes);
  localparam int CrcLoIdx   = FrameBytes - 2;
  localparam int CrcHiIdx   = FrameBytes - 1;

  localparam logic [15:0] CrcInit       = 16'hFFFF;
  localparam logic [15:0] CrcPoly       = 16'hA001;
  localparam logic [15:0] AddrBroadcast = 16'hFFFF;
  localparam logic [15:0] AddrMin       = 16'h0001;
  localparam logic [15:0] AddrMax       = 16'h00F7;
  localparam logic [7:0]  DefaultAddrReset = 8'h01;

  localparam int QueueDepthDefault = 2;

  // input operation codes
  localparam logic OpSend = 1'b0;
  localparam logic OpEcho = 1'b1;

  // result kinds
  localparam logic KindTx     = 1'b0;
  localparam logic KindStatus = 1'b1;

  // one classified item between front and back
  typedef struct packed {
    logic        op;
    logic [7:0]  dest_addr;
    logic [7:0]  function_code;
    logic [15:0] register_address;
    logic [15:0] register_value;
    logic        expect_echo;
    logic [7:0]  echo_byte;
  } entry_t;

  // back end status seen by the top level
  typedef struct packed {
    logic busy;
    logic armed;
  } back_status_t;

  // crc-16/modbus update by one byte, lsb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CrcPoly;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

// File: rtl/modbus_request_frame_builder_core.sv
// top level of the modbus rtu request frame builder with echo check
//
// usage:
// - cfg channel (cfg_valid_i/cfg_ready_o/cfg_data_i) writes the default slave
//   address; ready is always high, write only while the block is idle
// - input channel (in_valid_i/in_ready_o) takes send items (op 0) and echo
//   byte items (op 1); each transfer is pushed into a short queue
// - output channel (out_valid_o/out_ready_i) delivers transmit bytes and
//   echo check status results from an output register
// path: an accepted item is first written into the queue, then the back end loads
//   its result into the output register
// throughput: a send emits one frame byte per cycle while the receiver is ready, set by the
//   single output register and the byte-wide crc update in the back end;
//   an echo byte is taken from the queue with a single pop
// the crc-16/modbus is computed one byte per cycle while the output register is free, as the frame goes out, so
//   the crc bytes follow the six header bytes without a gap
// reset: queue empty, echo check disarmed, kept frame zero, default address 1
// when the receiver stalls the output register holds its result, the back end
//   waits, and the queue keeps accepting until it is full
module modbus_request_frame_builder_core #(
  parameter int QueueDepth = mfb_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [15:0] slave_address_i,
  input  logic [7:0]  function_code_i,
  input  logic [15:0] register_address_i,
  input  logic [15:0] register_value_i,
  input  logic        expect_echo_i,
  input  logic [7:0]  echo_byte_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  output logic        echo_done_o,
  output logic        echo_match_o
);

  // front to queue
  logic                  push;
  mfb_pkg::entry_t       push_entry;
  logic                  q_full;

  // queue to back
  mfb_pkg::entry_t       head;
  logic                  q_empty;
  logic                  pop;

  mfb_pkg::back_status_t back_status;

  mfb_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .op_i               (op_i),
    .slave_address_i    (slave_address_i),
    .function_code_i    (function_code_i),
    .register_address_i (register_address_i),
    .register_value_i   (register_value_i),
    .expect_echo_i      (expect_echo_i),
    .echo_byte_i        (echo_byte_i),
    .q_full_i           (q_full),
    .push_o             (push),
    .push_entry_o       (push_entry)
  );

  mfb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .empty_o      (q_empty),
    .full_o       (q_full)
  );

  // back end stalls on the output register, independent of the front
  mfb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .q_empty_i    (q_empty),
    .pop_o        (pop),
    .status_o     (back_status),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .tx_byte_o    (tx_byte_o),
    .last_o       (last_o),
    .echo_done_o  (echo_done_o),
    .echo_match_o (echo_match_o)
  );

`ifndef SYNTHESIS
  // while a frame is being sent the output register always holds a byte
  a_busy_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.busy |-> out_valid_o)
    else $error("frame in progress without a pending output byte");

  // the queue is never popped while a frame is still going out
  a_no_pop_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.busy |-> !pop)
    else $error("queue popped during frame emission");

  // last byte is a transmit result and ends the frame
  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_o |->
      (kind_o == mfb_pkg::KindTx) && !back_status.busy)
    else $error("last flag on a non-final or status result");

  // status results carry done, transmit results do not
  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((kind_o == mfb_pkg::KindStatus) == echo_done_o))
    else $error("echo_done does not match result kind");
`endif

endmodule

// File: rtl/mfb_front.sv
// front end: accepts items, substitutes the slave address, holds the config register
module mfb_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [7:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 op_i,
  input  logic [15:0]          slave_address_i,
  input  logic [7:0]           function_code_i,
  input  logic [15:0]          register_address_i,
  input  logic [15:0]          register_value_i,
  input  logic                 expect_echo_i,
  input  logic [7:0]           echo_byte_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output mfb_pkg::entry_t      push_entry_o
);

  logic [7:0] default_addr_q, default_addr_d;
  logic       addr_bad;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    default_addr_d = default_addr_q;
    if (cfg_valid_i) begin
      default_addr_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_addr_q <= mfb_pkg::DefaultAddrReset;
    end else begin
      default_addr_q <= default_addr_d;
    end
  end

  assign addr_bad = (slave_address_i == mfb_pkg::AddrBroadcast) ||
                    (slave_address_i < mfb_pkg::AddrMin) ||
                    (slave_address_i > mfb_pkg::AddrMax);

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    push_entry_o.op               = op_i;
    push_entry_o.dest_addr        = addr_bad ? default_addr_q : slave_address_i[7:0];
    push_entry_o.function_code    = function_code_i;
    push_entry_o.register_address = register_address_i;
    push_entry_o.register_value   = register_value_i;
    push_entry_o.expect_echo      = expect_echo_i;
    push_entry_o.echo_byte        = echo_byte_i;
  end

endmodule

// File: rtl/mfb_queue.sv
// small in-order queue of classified items between front and back
module mfb_queue #(
  parameter int Depth = mfb_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mfb_pkg::entry_t push_entry_i,
  input  logic            pop_i,
  output mfb_pkg::entry_t head_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  mfb_pkg::entry_t slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign head_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// File: rtl/mfb_back.sv
// back end: emits frame bytes with running crc, checks echo bytes, drives the output register
module mfb_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mfb_pkg::entry_t       head_i,
  input  logic                  q_empty_i,
  output logic                  pop_o,
  output mfb_pkg::back_status_t status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  kind_o,
  output logic [7:0]            tx_byte_o,
  output logic                  last_o,
  output logic                  echo_done_o,
  output logic                  echo_match_o
);

  localparam int IdxW = mfb_pkg::IdxW;

  logic [7:0]      frame_q [mfb_pkg::FrameBytes];
  logic [7:0]      frame_d [mfb_pkg::FrameBytes];
  logic [15:0]     crc_q, crc_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic            busy_q, busy_d;
  logic            armed_q, armed_d;

  logic            out_valid_q, out_valid_d;
  logic            kind_q, kind_d;
  logic [7:0]      tx_q, tx_d;
  logic            last_q, last_d;
  logic            done_q, done_d;
  logic            match_q, match_d;

  logic            out_free;
  logic [7:0]      emit_byte;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    unique case (idx_q)
      IdxW'(mfb_pkg::CrcLoIdx): emit_byte = crc_q[7:0];
      IdxW'(mfb_pkg::CrcHiIdx): emit_byte = crc_q[15:8];
      default:                  emit_byte = frame_q[idx_q];
    endcase
  end

  always_comb begin
    frame_d     = frame_q;
    crc_d       = crc_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    busy_d      = busy_q;
    armed_d     = armed_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    tx_d        = tx_q;
    last_d      = last_q;
    done_d      = done_q;
    match_d     = match_q;
    pop_o       = 1'b0;

    if (out_free) begin
      out_valid_d = 1'b0;
    end

    if (busy_q && out_free) begin
      // one frame byte per cycle while the output register is free, crc bytes captured into the kept frame
      frame_d[idx_q] = emit_byte;
      if (idx_q < IdxW'(mfb_pkg::CrcLoIdx)) begin
        crc_d = mfb_pkg::crc16_byte(crc_q, emit_byte);
      end
      out_valid_d = 1'b1;
      kind_d      = mfb_pkg::KindTx;
      tx_d        = emit_byte;
      last_d      = (idx_q == IdxW'(mfb_pkg::CrcHiIdx));
      done_d      = 1'b0;
      match_d     = 1'b0;
      idx_d       = idx_q + 1'b1;
      if (idx_q == IdxW'(mfb_pkg::CrcHiIdx)) begin
        busy_d = 1'b0;
      end
    end else if (!busy_q && !q_empty_i && out_free) begin
      pop_o = 1'b1;
      if (head_i.op == mfb_pkg::OpSend) begin
        frame_d[0]  = head_i.dest_addr;
        frame_d[1]  = head_i.function_code;
        frame_d[2]  = head_i.register_address[15:8];
        frame_d[3]  = head_i.register_address[7:0];
        frame_d[4]  = head_i.register_value[15:8];
        frame_d[5]  = head_i.register_value[7:0];
        crc_d       = mfb_pkg::crc16_byte(mfb_pkg::CrcInit, head_i.dest_addr);
        out_valid_d = 1'b1;
        kind_d      = mfb_pkg::KindTx;
        tx_d        = head_i.dest_addr;
        last_d      = 1'b0;
        done_d      = 1'b0;
        match_d     = 1'b0;
        idx_d       = IdxW'(1);
        busy_d      = 1'b1;
        armed_d     = head_i.expect_echo;
        pos_d       = '0;
      end else if (armed_q) begin
        if (head_i.echo_byte != frame_q[pos_q]) begin
          armed_d     = 1'b0;
          pos_d       = '0;
          out_valid_d = 1'b1;
          kind_d      = mfb_pkg::KindStatus;
          tx_d        = '0;
          last_d      = 1'b0;
          done_d      = 1'b1;
          match_d     = 1'b0;
        end else if (pos_q == IdxW'(mfb_pkg::CrcHiIdx)) begin
          armed_d     = 1'b0;
          pos_d       = '0;
          out_valid_d = 1'b1;
          kind_d      = mfb_pkg::KindStatus;
          tx_d        = '0;
          last_d      = 1'b0;
          done_d      = 1'b1;
          match_d     = 1'b1;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      armed_q     <= 1'b0;
      pos_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < mfb_pkg::FrameBytes; i++) begin
        frame_q[i] <= '0;
      end
    end else begin
      busy_q      <= busy_d;
      armed_q     <= armed_d;
      pos_q       <= pos_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      frame_q     <= frame_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q   <= crc_d;
    kind_q  <= kind_d;
    tx_q    <= tx_d;
    last_q  <= last_d;
    done_q  <= done_d;
    match_q <= match_d;
  end

  assign status_o.busy  = busy_q;
  assign status_o.armed = armed_q;

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign tx_byte_o    = tx_q;
  assign last_o       = last_q;
  assign echo_done_o  = done_q;
  assign echo_match_o = match_q;

endmodule

// File: dv/tb_top.sv
// self-checking testbench for the modbus rtu request frame builder with echo check
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mfb_pkg::*;

  // run shape
  localparam int NumDirRows    = 27;
  localparam int NumPhases     = 7;
  localparam int ItemsPerPhase = 50;
  // cycles to let queued echo bytes (which may give no result) leave the block
  localparam int SettleCycles  = 12;
  // cycles with no transfer on any channel before the run is declared hung
  localparam int StallLimit    = 2000;

  // how a directed row's expectation is typed in, if at all
  typedef enum logic [2:0] {
    ChkNone,      // predictor only
    ChkAddr,      // first frame byte typed in
    ChkSilent,    // no result at all
    ChkMismatch,  // one status result, echo_match low
    ChkMatch      // one status result, echo_match high
  } chk_e;

  // one input item as driven on the ports
  typedef struct packed {
    logic        op;
    logic [15:0] addr;
    logic [7:0]  fc;
    logic [15:0] reg_addr;
    logic [15:0] reg_val;
    logic        echo_req;
    logic [7:0]  echo_b;
  } stim_t;

  // one result as seen on the output ports
  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic       last;
    logic       echo_done;
    logic       echo_match;
  } frame_res_t;

  // directed stimulus row; from_frame takes the echo byte from the kept frame
  typedef struct packed {
    logic        op;
    logic [15:0] addr;
    logic [7:0]  fc;
    logic [15:0] reg_addr;
    logic [15:0] reg_val;
    logic        echo_req;
    logic [7:0]  echo_b;
    logic        from_frame;
    chk_e        chk;
    logic [7:0]  want_addr;
  } dir_row_t;

  localparam dir_row_t DirRows [NumDirRows] = '{
    // echo byte with no check armed since reset
    '{OpEcho, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, ChkSilent, 8'h00},
    // broadcast marker, zero, first value above range: reset default used
    '{OpSend, 16'hFFFF, 8'h03, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, ChkAddr, 8'h01},
    '{OpSend, 16'h0000, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, 8'hFF, 1'b0, ChkAddr, 8'h01},
    '{OpSend, 16'h00F8, 8'h00, 16'h8000, 16'h0001, 1'b0, 8'h00, 1'b0, ChkAddr, 8'h01},
    // lowest and highest valid address pass through
    '{OpSend, 16'h0001, 8'h01, 16'h0001, 16'h8000, 1'b0, 8'h00, 1'b0, ChkAddr, 8'h01},
    '{OpSend, 16'h00F7, 8'h80, 16'h00FF, 16'hFF00, 1'b0, 8'h00, 1'b0, ChkAddr, 8'hF7},
    // valid low byte but high byte set: still replaced
    '{OpSend, 16'h0105, 8'h04, 16'h5A5A, 16'hA5A5, 1'b0, 8'h00, 1'b0, ChkAddr, 8'h01},
    '{OpSend, 16'hFFFE, 8'h06, 16'h1234, 16'h5678, 1'b0, 8'h00, 1'b0, ChkAddr, 8'h01},
    // echo byte after a send without check is ignored
    '{OpEcho, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 8'h01, 1'b0, ChkSilent, 8'h00},
    // armed send, eight matching echo bytes
    '{OpSend, 16'h0011, 8'h04, 16'h1234, 16'hABCD, 1'b1, 8'h00, 1'b0, ChkAddr, 8'h11},
    '{OpEcho, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b1, ChkNone, 8'h00},
    '{OpEcho, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b1, ChkNone, 8'h00},
    '{OpEcho, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b1, ChkNone, 8'h00},
    '{OpEcho, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b1, ChkNone, 8'h00},
    '{OpEcho, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b1, ChkNone, 8'h00},
    '{OpEcho, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b1, ChkNone, 8'h00},
    '{OpEcho, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b1, ChkNone, 8'h00},
    '{OpEcho, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b1, ChkMatch, 8'h00},
    // check is over, further echo bytes ignored
    '{OpEcho, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h11, 1'b0, ChkSilent, 8'h00},
    // mismatch on the second byte (function code 0x06 vs 0x00)
    '{OpSend, 16'h0022, 8'h06, 16'h0001, 16'h8000, 1'b1, 8'h00, 1'b0, ChkAddr, 8'h22},
    '{OpEcho, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b1, ChkNone, 8'h00},
    '{OpEcho, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, ChkMismatch, 8'h00},
    // new send while a check is running restarts it at position zero
    '{OpSend, 16'h0033, 8'h03, 16'h0010, 16'h0002, 1'b1, 8'h00, 1'b0, ChkAddr, 8'h33},
    '{OpEcho, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b1, ChkNone, 8'h00},
    '{OpSend, 16'h0044, 8'h10, 16'hBEEF, 16'h0F0F, 1'b1, 8'h00, 1'b0, ChkAddr, 8'h44},
    '{OpEcho, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h33, 1'b0, ChkMismatch, 8'h00},
    '{OpEcho, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h44, 1'b0, ChkSilent, 8'h00}
  };

  // dut ports, all known from time zero
  logic        clk_i              = 1'b0;
  logic        rst_ni             = 1'b0;
  logic        cfg_valid_i        = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i         = 8'h00;
  logic        in_valid_i         = 1'b0;
  logic        in_ready_o;
  logic        op_i               = OpSend;
  logic [15:0] slave_address_i    = 16'h0000;
  logic [7:0]  function_code_i    = 8'h00;
  logic [15:0] register_address_i = 16'h0000;
  logic [15:0] register_value_i   = 16'h0000;
  logic        expect_echo_i      = 1'b0;
  logic [7:0]  echo_byte_i        = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i        = 1'b0;
  logic        kind_o;
  logic [7:0]  tx_byte_o;
  logic        last_o;
  logic        echo_done_o;
  logic        echo_match_o;

  // predictor state: kept frame, echo check position and arming, default address
  logic [7:0]  kept_frame [FrameBytes];
  logic [2:0]  check_pos    = '0;
  logic        check_armed  = 1'b0;
  logic [7:0]  default_addr = DefaultAddrReset;

  // results still owed by the block, oldest first
  frame_res_t  due_results [$];

  int          mismatches = 0;
  bit          tx_idle    = 1'b1;  // sender inserts gaps
  bit          rx_idle    = 1'b1;  // receiver inserts stalls
  int          rx_hold    = 0;

  modbus_request_frame_builder_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .op_i               (op_i),
    .slave_address_i    (slave_address_i),
    .function_code_i    (function_code_i),
    .register_address_i (register_address_i),
    .register_value_i   (register_value_i),
    .expect_echo_i      (expect_echo_i),
    .echo_byte_i        (echo_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .kind_o             (kind_o),
    .tx_byte_o          (tx_byte_o),
    .last_o             (last_o),
    .echo_done_o        (echo_done_o),
    .echo_match_o       (echo_match_o)
  );

  always #4 clk_i = ~clk_i;

  // gap length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 16) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  // crc-16/modbus over the six header bytes, bit-serial, lsb first
  function automatic logic [15:0] modbus_crc6(input logic [47:0] hdr);
    logic [15:0] acc;
    acc = CrcInit;
    for (int i = 0; i < 6; i++) begin
      acc ^= {8'h00, hdr[47-8*i -: 8]};
      for (int b = 0; b < 8; b++) begin
        acc = acc[0] ? ((acc >> 1) ^ CrcPoly) : (acc >> 1);
      end
    end
    return acc;
  endfunction

  // advance the predictor by one accepted item and queue what it owes;
  // returns the number of results, or -1 for an echo byte that is ignored
  function automatic int predict_frame_or_echo(input stim_t s);
    logic [7:0]  addr_byte;
    logic [15:0] crc;
    frame_res_t  r;
    if (s.op == OpSend) begin
      // broadcast marker or out-of-range address falls back to the default
      if (s.addr == AddrBroadcast || s.addr < AddrMin || s.addr > AddrMax) begin
        addr_byte = default_addr;
      end else begin
        addr_byte = s.addr[7:0];
      end
      kept_frame[0] = addr_byte;
      kept_frame[1] = s.fc;
      kept_frame[2] = s.reg_addr[15:8];
      kept_frame[3] = s.reg_addr[7:0];
      kept_frame[4] = s.reg_val[15:8];
      kept_frame[5] = s.reg_val[7:0];
      crc = modbus_crc6({kept_frame[0], kept_frame[1], kept_frame[2],
                         kept_frame[3], kept_frame[4], kept_frame[5]});
      kept_frame[CrcLoIdx] = crc[7:0];
      kept_frame[CrcHiIdx] = crc[15:8];
      for (int k = 0; k < FrameBytes; k++) begin
        r = '{KindTx, kept_frame[k], k == FrameBytes - 1, 1'b0, 1'b0};
        due_results.push_back(r);
      end
      // a new send drops any running check and restarts at byte zero
      check_armed = s.echo_req;
      check_pos   = '0;
      return FrameBytes;
    end
    if (!check_armed) return -1;
    // status at the first mismatch or after the last frame byte
    if (s.echo_b != kept_frame[check_pos] || check_pos == FrameBytes - 1) begin
      r = '{KindStatus, 8'h00, 1'b0, 1'b1, s.echo_b == kept_frame[check_pos]};
      due_results.push_back(r);
      check_armed = 1'b0;
      check_pos   = '0;
      return 1;
    end
    check_pos++;
    return 0;
  endfunction

  // random send item with all fields random; address biased to the edges
  function automatic stim_t make_send(input logic echo_req);
    stim_t s;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: s.addr = 16'($urandom_range(AddrMin, AddrMax));
      4:          s.addr = 16'h0000;
      5:          s.addr = AddrBroadcast;
      6:          s.addr = 16'($urandom_range(AddrMax + 1, AddrBroadcast - 1));
      default:    s.addr = 16'($urandom);
    endcase
    s.op       = OpSend;
    s.fc       = 8'($urandom);
    s.reg_addr = 16'($urandom);
    s.reg_val  = 16'($urandom);
    s.echo_req = echo_req;
    s.echo_b   = 8'($urandom);
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    $display("tb_top: mismatch on %s, got 0x%0h, want 0x%0h", what, got, want);
  endtask

  // one input transfer; the typed expectation of a directed row, if any,
  // replaces what the predictor queued before the block can deliver it
  task automatic drive_item(input stim_t s, input chk_e chk, input logic [7:0] want,
                            output int n);
    frame_res_t r;
    in_valid_i         <= 1'b1;
    op_i               <= s.op;
    slave_address_i    <= s.addr;
    function_code_i    <= s.fc;
    register_address_i <= s.reg_addr;
    register_value_i   <= s.reg_val;
    expect_echo_i      <= s.echo_req;
    echo_byte_i        <= s.echo_b;
    do @(posedge clk_i); while (!in_ready_o);
    n = predict_frame_or_echo(s);
    case (chk)
      ChkAddr: begin
        r = due_results[due_results.size() - FrameBytes];
        r.tx_byte = want;
        due_results[due_results.size() - FrameBytes] = r;
      end
      ChkSilent, ChkMismatch, ChkMatch: begin
        repeat (n > 0 ? n : 0) void'(due_results.pop_back());
        if (chk != ChkSilent) begin
          r = '{KindStatus, 8'h00, 1'b0, 1'b1, chk == ChkMatch};
          due_results.push_back(r);
        end
      end
      default: ;
    endcase
    // random gap after the transfer, only while the sender is in an idle stretch
    if (tx_idle && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
    end
  endtask

  // hold off the sender until every owed result has been delivered
  task automatic wait_drained();
    if (due_results.size() != 0) begin
      in_valid_i <= 1'b0;
      while (due_results.size() != 0) @(posedge clk_i);
    end
  endtask

  // drained and settled: queued echo bytes with no result have left the block
  task automatic quiesce();
    wait_drained();
    in_valid_i <= 1'b0;
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // one random burst: mostly an armed send followed by its echo, sometimes
  // cut short or corrupted, else a plain send or some stray echo bytes
  task automatic run_burst(inout int counted);
    stim_t s;
    int    sel;
    int    nbytes;
    int    bad_at;
    int    n;
    if ($urandom_range(0, 7) == 0) tx_idle = !tx_idle;
    if ($urandom_range(0, 39) == 0) wait_drained();
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      s = make_send(1'b1);
      drive_item(s, ChkNone, 8'h00, n);
      counted++;
      nbytes = (sel < 4) ? FrameBytes : $urandom_range(1, FrameBytes - 1);
      bad_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, nbytes - 1) : -1;
      for (int k = 0; k < nbytes; k++) begin
        s        = make_send(1'b0);
        s.op     = OpEcho;
        s.echo_b = kept_frame[check_pos];
        if (k == bad_at) s.echo_b ^= 8'($urandom_range(1, 255));
        drive_item(s, ChkNone, 8'h00, n);
        if (n >= 0) counted++;
        if (!check_armed) break;
      end
    end else if (sel < 8) begin
      s = make_send(1'b0);
      drive_item(s, ChkNone, 8'h00, n);
      counted++;
    end else begin
      repeat ($urandom_range(1, 3)) begin
        s    = make_send($urandom_range(0, 1));
        s.op = OpEcho;
        drive_item(s, ChkNone, 8'h00, n);
        if (n >= 0) counted++;
      end
    end
  endtask

  // receiver: random stalls in idle stretches, long runs of ready between them
  always @(posedge clk_i) begin
    if (rx_hold != 0) begin
      out_ready_i <= 1'b0;
      rx_hold--;
    end else begin
      out_ready_i <= 1'b1;
      if (rx_idle && $urandom_range(0, 2) == 0) rx_hold = pick_gap();
    end
    if ($urandom_range(0, 63) == 0) rx_idle = !rx_idle;
  end

  // result checker: every output transfer against the oldest owed result
  always @(posedge clk_i) begin : result_check
    frame_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with nothing owed (tx_byte)", tx_byte_o, 8'h00);
      end else begin
        e = due_results.pop_front();
        if (kind_o !== e.kind) report_mismatch("kind", kind_o, e.kind);
        if (tx_byte_o !== e.tx_byte) report_mismatch("tx_byte", tx_byte_o, e.tx_byte);
        if (last_o !== e.last) report_mismatch("last", last_o, e.last);
        if (echo_done_o !== e.echo_done) report_mismatch("echo_done", echo_done_o, e.echo_done);
        if (echo_match_o !== e.echo_match) begin
          report_mismatch("echo_match", echo_match_o, e.echo_match);
        end
      end
    end
  end

  // watchdog: ends the run when no channel has moved a transfer for too long
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin : stimulus
    dir_row_t   row;
    stim_t      s;
    int         n;
    int         counted;
    logic [7:0] cfg_val;
    for (int k = 0; k < FrameBytes; k++) kept_frame[k] = 8'h00;

    // reset held low from time zero, released once
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows, default address still at its reset value
    for (int i = 0; i < NumDirRows; i++) begin
      row        = DirRows[i];
      s.op       = row.op;
      s.addr     = row.addr;
      s.fc       = row.fc;
      s.reg_addr = row.reg_addr;
      s.reg_val  = row.reg_val;
      s.echo_req = row.echo_req;
      s.echo_b   = row.from_frame ? kept_frame[check_pos] : row.echo_b;
      drive_item(s, row.chk, row.want_addr, n);
    end

    // random phases, each behind a default address write while idle;
    // extremes of the register first, then random valid values
    for (int p = 0; p < NumPhases; p++) begin
      quiesce();
      case (p)
        0:       cfg_val = AddrMax[7:0];
        1:       cfg_val = 8'h00;
        2:       cfg_val = 8'hFF;
        3:       cfg_val = DefaultAddrReset;
        default: cfg_val = 8'($urandom_range(AddrMin, AddrMax));
      endcase
      cfg_valid_i <= 1'b1;
      cfg_data_i  <= cfg_val;
      do @(posedge clk_i); while (!cfg_ready_o);
      default_addr = cfg_val;
      cfg_valid_i <= 1'b0;
      counted = 0;
      while (counted < ItemsPerPhase) run_burst(counted);
    end

    // drain, let the tail settle, then the verdict
    quiesce();
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
